// File: rtl/cst_pkg.sv
// Shared constants and result type of the comment-skipping tokenizer.
// No dependencies; imported by the scan core and the top level.
`timescale 1ns / 1ps

package cst_pkg;

  // Longest word kept; a quoted token keeps one byte less
  localparam int unsigned TOKEN_LIMIT = 1024;
  localparam int unsigned LEN_W       = $clog2(TOKEN_LIMIT + 1);

  // Byte classes
  localparam logic [7:0] CH_END     = 8'h00;
  localparam logic [7:0] CH_SEP_MAX = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NL      = 8'h0A;

  // One result of the scan core; emit marks that an item leaves
  typedef struct packed {
    logic       emit;
    logic [7:0] token_byte;
    logic       byte_valid;
    logic       token_last;
    logic       token_quoted;
    logic       token_dropped;
  } tok_res_t;

endpackage

// File: rtl/cst_text_if.sv
// Input channel of the tokenizer: one text byte per item.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps

interface cst_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// File: rtl/cst_token_if.sv
// Output channel of the tokenizer: one token byte with its markers per item.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps

interface cst_token_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       byte_valid;
  logic       token_last;
  logic       token_quoted;
  logic       token_dropped;

  modport source (output valid, output token_byte, output byte_valid, output token_last,
                  output token_quoted, output token_dropped, input ready);
  modport sink   (input valid, input token_byte, input byte_valid, input token_last,
                  input token_quoted, input token_dropped, output ready);
endinterface

// File: rtl/cst_scan.sv
// Scan core: mode register, held byte and token length, with the per-byte step logic.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_scan
  import cst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output tok_res_t   res_o
);

  localparam logic [2:0] MODE_BETWEEN    = 3'd0;
  localparam logic [2:0] MODE_SLASH      = 3'd1;
  localparam logic [2:0] MODE_LINE_CMT   = 3'd2;
  localparam logic [2:0] MODE_BLOCK_CMT  = 3'd3;
  localparam logic [2:0] MODE_BLOCK_STAR = 3'd4;
  localparam logic [2:0] MODE_QUOTED     = 3'd5;
  localparam logic [2:0] MODE_WORD       = 3'd6;

  localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_WORD  = LEN_W'(TOKEN_LIMIT);
  localparam logic [LEN_W-1:0] LEN_QUOTE = LEN_W'(TOKEN_LIMIT - 1);

  logic [2:0]       mode_q, mode_d;
  logic [7:0]       held_byte_q, held_byte_d;
  logic             held_valid_q, held_valid_d;
  logic [LEN_W-1:0] len_q, len_d;

  // Word step inputs: what is held going into the word byte
  logic [7:0]       wb_held;
  logic [LEN_W-1:0] wb_len;
  logic             wb_run;
  logic             is_sep;

  assign is_sep = (byte_i <= CH_SEP_MAX);

  // Step the scan for one byte
  always_comb begin
    mode_d       = mode_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    len_d        = len_q;
    res_o        = '0;
    wb_held      = held_byte_q;
    wb_len       = len_q;
    wb_run       = 1'b0;

    case (mode_q)
      MODE_SLASH: begin
        if (byte_i == CH_SLASH) begin
          mode_d = MODE_LINE_CMT;
        end else if (byte_i == CH_STAR) begin
          mode_d = MODE_BLOCK_CMT;
        end else begin
          // lone slash opens a word
          held_byte_d  = CH_SLASH;
          held_valid_d = 1'b1;
          len_d        = LEN_ONE;
          mode_d       = MODE_WORD;
          wb_held      = CH_SLASH;
          wb_len       = LEN_ONE;
          wb_run       = 1'b1;
        end
      end
      MODE_LINE_CMT: begin
        if (byte_i == CH_END || byte_i == CH_NL) begin
          mode_d = MODE_BETWEEN;
        end
      end
      MODE_BLOCK_CMT: begin
        if (byte_i == CH_END) begin
          mode_d = MODE_BETWEEN;
        end else if (byte_i == CH_STAR) begin
          mode_d = MODE_BLOCK_STAR;
        end
      end
      MODE_BLOCK_STAR: begin
        if (byte_i == CH_END || byte_i == CH_SLASH) begin
          mode_d = MODE_BETWEEN;
        end else if (byte_i != CH_STAR) begin
          mode_d = MODE_BLOCK_CMT;
        end
      end
      MODE_QUOTED: begin
        if (byte_i == CH_END || byte_i == CH_QUOTE) begin
          // close the quoted token, byteless when nothing was held
          res_o.emit         = 1'b1;
          res_o.token_byte   = held_valid_q ? held_byte_q : 8'h00;
          res_o.byte_valid   = held_valid_q;
          res_o.token_last   = 1'b1;
          res_o.token_quoted = 1'b1;
          held_byte_d        = 8'h00;
          held_valid_d       = 1'b0;
          len_d              = '0;
          mode_d             = MODE_BETWEEN;
        end else if (len_q < LEN_QUOTE) begin
          len_d = len_q + LEN_ONE;
          if (held_valid_q) begin
            res_o.emit         = 1'b1;
            res_o.token_byte   = held_byte_q;
            res_o.byte_valid   = 1'b1;
            res_o.token_quoted = 1'b1;
          end
          held_byte_d  = byte_i;
          held_valid_d = 1'b1;
        end
      end
      MODE_WORD: begin
        if (!held_valid_q) begin
          held_byte_d  = 8'h00;
          held_valid_d = 1'b0;
          len_d        = '0;
          mode_d       = MODE_BETWEEN;
        end else begin
          wb_run = 1'b1;
        end
      end
      default: begin
        if (is_sep) begin
          held_byte_d  = 8'h00;
          held_valid_d = 1'b0;
          len_d        = '0;
          mode_d       = MODE_BETWEEN;
        end else if (byte_i == CH_SLASH) begin
          held_valid_d = 1'b0;
          len_d        = '0;
          mode_d       = MODE_SLASH;
        end else if (byte_i == CH_QUOTE) begin
          held_byte_d  = 8'h00;
          held_valid_d = 1'b0;
          len_d        = '0;
          mode_d       = MODE_QUOTED;
        end else begin
          held_byte_d  = byte_i;
          held_valid_d = 1'b1;
          len_d        = LEN_ONE;
          mode_d       = MODE_WORD;
        end
      end
    endcase

    // Word byte: pass the held byte on below the limit, close the word at a separator
    if (wb_run) begin
      if (!is_sep) begin
        if (wb_len < LEN_WORD) begin
          res_o.emit       = 1'b1;
          res_o.token_byte = wb_held;
          res_o.byte_valid = 1'b1;
          held_byte_d      = byte_i;
          len_d            = wb_len + LEN_ONE;
        end
      end else begin
        res_o.emit          = 1'b1;
        res_o.token_byte    = wb_held;
        res_o.byte_valid    = 1'b1;
        res_o.token_last    = 1'b1;
        res_o.token_dropped = (wb_len >= LEN_WORD);
        held_byte_d         = 8'h00;
        held_valid_d        = 1'b0;
        len_d               = '0;
        mode_d              = MODE_BETWEEN;
      end
    end
  end

  // Advance the scan state on each stepped byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_BETWEEN;
      held_byte_q  <= 8'h00;
      held_valid_q <= 1'b0;
      len_q        <= '0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      len_q        <= len_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A word in progress always holds a byte
  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_WORD) |-> held_valid_q)
    else $error("word mode without a held byte");

  // Kept length never passes the word limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_WORD)
    else $error("token length beyond limit");

  // Comment modes carry no token
  a_cmt_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_LINE_CMT || mode_q == MODE_BLOCK_CMT || mode_q == MODE_BLOCK_STAR)
      |-> !held_valid_q)
    else $error("held byte inside a comment");
`endif

endmodule

// File: rtl/comment_skipping_tokenizer.sv
// Order: an accepted byte is registered, then stepped once the result register
// can take its result; its result (if any) is presented from the result register.
// Throughput: one byte per cycle while results are taken; a result that waits on a
// stalled output holds the registered byte, so text input stalls with the output.
// Reset: asynchronous, active low; scan state returns to between tokens, both
// registers empty.
`timescale 1ns / 1ps

module comment_skipping_tokenizer
  import cst_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  cst_text_if.sink     txt_i,
  cst_token_if.source  tok_o
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       out_vld_q, out_vld_d;
  tok_res_t   out_q, out_d;
  tok_res_t   step_res;
  logic       advance;

  // Step the held byte when the result register can take its result
  assign advance     = in_vld_q && (!out_vld_q || tok_o.ready);
  assign txt_i.ready = !in_vld_q || advance;

  cst_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (step_res)
  );

  // Load the input register, refill the result register
  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (txt_i.ready) begin
      in_vld_d = txt_i.valid;
      if (txt_i.valid) begin
        in_byte_d = txt_i.text_byte;
      end
    end
    if (advance) begin
      out_vld_d = step_res.emit;
      out_d     = step_res;
    end else if (tok_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    out_q     <= out_d;
  end

  assign tok_o.valid         = out_vld_q;
  assign tok_o.token_byte    = out_q.token_byte;
  assign tok_o.byte_valid    = out_q.byte_valid;
  assign tok_o.token_last    = out_q.token_last;
  assign tok_o.token_quoted  = out_q.token_quoted;
  assign tok_o.token_dropped = out_q.token_dropped;

`ifndef NO_ASSERTIONS
  // Drop flag only on the closing item of a word
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.token_dropped) |-> (out_q.token_last && !out_q.token_quoted))
    else $error("drop flag outside a word's last item");

  // A byteless item is only the close of an empty quoted token
  a_empty_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.byte_valid)
      |-> (out_q.token_last && out_q.token_quoted && out_q.token_byte == 8'h00))
    else $error("byteless item that is not an empty quoted token");

  // A stalled result blocks stepping of the held byte
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !tok_o.ready) |=> in_vld_q)
    else $error("held byte lost during output stall");
`endif

endmodule

// File: dv/cst_token_check.sv
// Scoreboard of the comment-skipping tokenizer: predicts the token items from the
// accepted text bytes and compares them with what the block hands out.
// Depends on cst_pkg and on the cst_text_if and cst_token_if interfaces.
`timescale 1ns / 1ps

module cst_token_check
  import cst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cst_text_if         txt_i,
  cst_token_if        tok_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned tokens_o
);

  typedef enum logic [2:0] {
    SCAN_BETWEEN,
    SCAN_SLASH,
    SCAN_LINE_CMT,
    SCAN_BLOCK_CMT,
    SCAN_BLOCK_STAR,
    SCAN_QUOTED,
    SCAN_WORD
  } scan_mode_e;

  // Predicted scan state
  scan_mode_e  mode;
  logic [7:0]  hold_byte;
  logic        hold_vld;
  int unsigned tok_len;

  // Token items still owed by the block, oldest first
  tok_res_t    token_q[$];
  int unsigned n_err;
  int unsigned n_res;
  int unsigned n_tok;

  function automatic void close_token();
    hold_byte = '0;
    hold_vld  = 1'b0;
    tok_len   = 0;
    mode      = SCAN_BETWEEN;
  endfunction

  function automatic tok_res_t make_item(logic [7:0] b, logic bv, logic last,
                                         logic quoted, logic dropped);
    tok_res_t r;
    r.emit          = 1'b1;
    r.token_byte    = b;
    r.byte_valid    = bv;
    r.token_last    = last;
    r.token_quoted  = quoted;
    r.token_dropped = dropped;
    return r;
  endfunction

  // Advance a word by one byte; a byte is always held here
  function automatic tok_res_t word_step(logic [7:0] b);
    tok_res_t r = '0;
    if (b > CH_SEP_MAX) begin
      if (tok_len < TOKEN_LIMIT) begin
        r = make_item(hold_byte, 1'b1, 1'b0, 1'b0, 1'b0);
        hold_byte = b;
        tok_len++;
      end
    end else begin
      r = make_item(hold_byte, 1'b1, 1'b1, 1'b0, tok_len >= TOKEN_LIMIT);
      close_token();
    end
    return r;
  endfunction

  // Step the scan by one text byte; emit is set when an item leaves
  function automatic tok_res_t scan_step(logic [7:0] b);
    tok_res_t r = '0;
    case (mode)
      SCAN_SLASH: begin
        if (b == CH_SLASH) begin
          mode = SCAN_LINE_CMT;
        end else if (b == CH_STAR) begin
          mode = SCAN_BLOCK_CMT;
        end else begin
          // lone slash opens a word
          hold_byte = CH_SLASH;
          hold_vld  = 1'b1;
          tok_len   = 1;
          mode      = SCAN_WORD;
          r = word_step(b);
        end
      end
      SCAN_LINE_CMT: begin
        if (b == CH_END || b == CH_NL) mode = SCAN_BETWEEN;
      end
      SCAN_BLOCK_CMT: begin
        if (b == CH_END) mode = SCAN_BETWEEN;
        else if (b == CH_STAR) mode = SCAN_BLOCK_STAR;
      end
      SCAN_BLOCK_STAR: begin
        if (b == CH_END || b == CH_SLASH) mode = SCAN_BETWEEN;
        else if (b != CH_STAR) mode = SCAN_BLOCK_CMT;
      end
      SCAN_QUOTED: begin
        if (b == CH_END || b == CH_QUOTE) begin
          if (hold_vld) r = make_item(hold_byte, 1'b1, 1'b1, 1'b1, 1'b0);
          else r = make_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
          close_token();
        end else if (tok_len < TOKEN_LIMIT - 1) begin
          // keep the byte; release the one held before it
          tok_len++;
          if (hold_vld) r = make_item(hold_byte, 1'b1, 1'b0, 1'b1, 1'b0);
          hold_byte = b;
          hold_vld  = 1'b1;
        end
      end
      SCAN_WORD: begin
        if (!hold_vld) close_token();
        else r = word_step(b);
      end
      default: begin
        if (b <= CH_SEP_MAX) begin
          close_token();
        end else if (b == CH_SLASH) begin
          hold_vld = 1'b0;
          tok_len  = 0;
          mode     = SCAN_SLASH;
        end else if (b == CH_QUOTE) begin
          hold_byte = '0;
          hold_vld  = 1'b0;
          tok_len   = 0;
          mode      = SCAN_QUOTED;
        end else begin
          hold_byte = b;
          hold_vld  = 1'b1;
          tok_len   = 1;
          mode      = SCAN_WORD;
        end
      end
    endcase
    return r;
  endfunction

  // Check the item leaving the block, then predict from the byte entering it
  always @(posedge clk_i or negedge rst_ni) begin
    tok_res_t want;
    tok_res_t got;
    if (!rst_ni) begin
      close_token();
      token_q.delete();
      n_err = 0;
      n_res = 0;
      n_tok = 0;
    end else begin
      if (tok_i.valid && tok_i.ready) begin
        got = make_item(tok_i.token_byte, tok_i.byte_valid, tok_i.token_last,
                        tok_i.token_quoted, tok_i.token_dropped);
        n_res++;
        if (got.token_last === 1'b1) n_tok++;
        if (token_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected token item byte=%02h valid=%b last=%b quoted=%b dropped=%b",
                   $time, got.token_byte, got.byte_valid, got.token_last,
                   got.token_quoted, got.token_dropped);
        end else begin
          want = token_q.pop_front();
          if (got.token_byte !== want.token_byte || got.byte_valid !== want.byte_valid ||
              got.token_last !== want.token_last || got.token_quoted !== want.token_quoted ||
              got.token_dropped !== want.token_dropped) begin
            n_err++;
            $display("%0t: token item mismatch: expected byte=%02h valid=%b last=%b quoted=%b dropped=%b",
                     $time, want.token_byte, want.byte_valid, want.token_last,
                     want.token_quoted, want.token_dropped);
            $display("%0t:                      actual   byte=%02h valid=%b last=%b quoted=%b dropped=%b",
                     $time, got.token_byte, got.byte_valid, got.token_last,
                     got.token_quoted, got.token_dropped);
          end
        end
      end
      if (txt_i.valid && txt_i.ready) begin
        want = scan_step(txt_i.text_byte);
        if (want.emit) token_q.push_back(want);
      end
    end
    errors_o  <= n_err;
    pending_o <= token_q.size();
    results_o <= n_res;
    tokens_o  <= n_tok;
  end

endmodule

// File: dv/tb_comment_skipping_tokenizer.sv
// Testbench top of the comment-skipping tokenizer: drives text bytes with random
// gaps and output stalls, and reports the verdict of the cst_token_check scoreboard.
// Depends on cst_pkg, the channel interfaces, the block and cst_token_check.
`timescale 1ns / 1ps

module tb_comment_skipping_tokenizer;
  import cst_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned TAIL_CYCLES  = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cst_text_if  txt ();
  cst_token_if tok ();

  int unsigned errors;
  int unsigned pending;
  int unsigned results;
  int unsigned tokens;
  int unsigned n_sent;
  int unsigned long_bytes;
  int unsigned cycles;
  bit          idle_on;

  comment_skipping_tokenizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .txt_i  (txt),
    .tok_o  (tok)
  );

  cst_token_check i_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .txt_i     (txt),
    .tok_i     (tok),
    .errors_o  (errors),
    .pending_o (pending),
    .results_o (results),
    .tokens_o  (tokens)
  );

  always #10 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d token items outstanding",
               $time, cycles, pending);
      $display("[comment_skipping_tokenizer] ERROR");
      $finish;
    end
  end

  // Stall the token side in random bursts
  initial begin
    int stall;
    stall = 0;
    tok.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        tok.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 5) - 1;
        tok.ready <= 1'b0;
      end else begin
        tok.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_byte(int unsigned lo, int unsigned hi,
                                           logic [7:0] ex_a, logic [7:0] ex_b);
    logic [7:0] b;
    do b = 8'($urandom_range(lo, hi)); while (b == ex_a || b == ex_b);
    return b;
  endfunction

  // Offer one text byte, with an optional gap first; return once it is taken
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      txt.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    txt.valid     <= 1'b1;
    txt.text_byte <= b;
    @(posedge clk_i);
    while (!txt.ready) @(posedge clk_i);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic send_sep();
    send_byte(8'($urandom_range(0, 32)));
  endtask

  // Word whose first byte opens a word, not a comment or a quote
  task automatic send_word(int unsigned len);
    send_byte(pick_byte(33, 255, CH_SLASH, CH_QUOTE));
    for (int unsigned k = 1; k < len; k++) send_byte(pick_byte(33, 255, 8'h00, 8'h00));
  endtask

  task automatic send_quoted(int unsigned len);
    send_byte(CH_QUOTE);
    for (int unsigned k = 0; k < len; k++) send_byte(pick_byte(1, 255, CH_QUOTE, CH_QUOTE));
    send_byte(($urandom_range(0, 9) == 0) ? CH_END : CH_QUOTE);
  endtask

  // Directed text followed by random segments of well-formed and broken tokens
  initial begin
    logic [7:0]  dtext [$];
    int unsigned seg;
    int unsigned kind;
    int unsigned len;
    txt.valid     <= 1'b0;
    txt.text_byte <= 8'h00;
    idle_on    = 1'b1;
    n_sent     = 0;
    long_bytes = 0;
    cycles     = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // max byte word cut by text end, empty quote, lone slash word, line comment,
    // star-heavy block comment, one-byte word, quote cut by text end,
    // lone slash at text end, unclosed block comment
    dtext = '{8'hFF, CH_END, CH_QUOTE, CH_QUOTE, CH_SLASH, 8'h78, 8'h01,
              CH_SLASH, CH_SLASH, 8'hFF, CH_NL, CH_SLASH, CH_STAR, CH_STAR, CH_STAR,
              CH_SLASH, 8'h21, CH_SEP_MAX, CH_QUOTE, 8'h71, CH_END, CH_SLASH, CH_END,
              CH_SLASH, CH_STAR, 8'h7A, CH_END};
    foreach (dtext[k]) send_byte(dtext[k]);

    seg = 0;
    while (n_sent - dtext.size() - long_bytes < RANDOM_BYTES) begin
      if (n_sent - dtext.size() - long_bytes > RANDOM_BYTES * 4 / 5) idle_on = 1'b0;
      seg++;
      // long tokens around the length limit
      if (seg == 15 || seg == 40 || seg == 65) begin
        len = (seg == 15) ? TOKEN_LIMIT - 1 : (seg == 40) ? TOKEN_LIMIT : TOKEN_LIMIT + 3;
        send_word(len);
        send_sep();
        long_bytes += len + 1;
        continue;
      end
      if (seg == 90 || seg == 115) begin
        len = (seg == 90) ? TOKEN_LIMIT - 1 : TOKEN_LIMIT + 2;
        send_quoted(len);
        long_bytes += len + 2;
        continue;
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        send_word($urandom_range(1, 8));
        send_sep();
      end else if (kind < 50) begin
        send_quoted($urandom_range(0, 8));
        if ($urandom_range(0, 1) == 0) send_sep();
      end else if (kind < 60) begin
        send_byte(CH_SLASH);
        send_byte(CH_SLASH);
        len = $urandom_range(0, 6);
        repeat (len) send_byte(pick_byte(1, 255, CH_NL, CH_NL));
        send_byte(($urandom_range(0, 9) == 0) ? CH_END : CH_NL);
      end else if (kind < 70) begin
        send_byte(CH_SLASH);
        send_byte(CH_STAR);
        len = $urandom_range(0, 6);
        repeat (len) begin
          if ($urandom_range(0, 2) == 0) send_byte(CH_STAR);
          else send_byte(pick_byte(1, 255, CH_STAR, CH_STAR));
        end
        if ($urandom_range(0, 9) == 0) begin
          send_byte(CH_END);
        end else begin
          send_byte(CH_STAR);
          send_byte(CH_SLASH);
        end
      end else if (kind < 78) begin
        // slash that turns out to start a word
        send_byte(CH_SLASH);
        len = $urandom_range(0, 4);
        if (len > 0) begin
          send_byte(pick_byte(33, 255, CH_SLASH, CH_STAR));
          repeat (len - 1) send_byte(pick_byte(33, 255, 8'h00, 8'h00));
        end
        send_sep();
      end else if (kind < 88) begin
        send_sep();
      end else if (kind < 92) begin
        send_byte(CH_END);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    send_byte(CH_END);
    txt.valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Fed %0d text bytes (%0d in tokens near the length limit) over %0d segments;",
             n_sent, long_bytes, seg);
    $display("checked %0d token items closing %0d tokens, %0d mismatches.",
             results, tokens, errors);
    if (errors == 0 && pending == 0) begin
      $display("[comment_skipping_tokenizer] OK");
    end else begin
      $display("[comment_skipping_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
